// ===== rtl/sddt_pkg.sv =====
// ----------------------------------------------------------------------------
// sddt_pkg
// Shared sizes and types for the signature dedup table.
// ----------------------------------------------------------------------------
`default_nettype none

package sddt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int SIG_LEN     = 256;

  localparam int ELEM_W  = 5;
  localparam int ACC_W   = 13;
  localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CNT_W   = (COUNT_W > 7) ? COUNT_W : 7;
  localparam int POS_W   = $clog2(SIG_LEN);
  localparam int PCNT_W  = $clog2(SIG_LEN + 1);

  localparam int STORE_AW    = ENTRY_W + POS_W;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  localparam logic [ACC_W:0] ACC_LIMIT = (ACC_W + 1)'((1 << ACC_W) - 1);
  localparam logic [ACC_W-1:0] MAX_DIST_RST = ACC_W'(72);

  // Per-element control handed to the SAD unit
  typedef struct packed {
    logic             pos_ok;        // element lands inside the signature
    logic [ACC_W-1:0] dist_limit;
  } sddt_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sddt_ram.sv =====
// ----------------------------------------------------------------------------
// sddt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sddt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sddt_sad_unit.sv =====
// ----------------------------------------------------------------------------
// sddt_sad_unit
// Absolute difference, saturating accumulate and distance threshold check.
// ----------------------------------------------------------------------------
`default_nettype none

module sddt_sad_unit import sddt_pkg::*; (
  input  wire sddt_ctl_t         ctl,
  input  wire logic [ELEM_W-1:0] stored_elem,
  input  wire logic [ELEM_W-1:0] query_elem,
  input  wire logic [ACC_W-1:0]  acc_old,
  output logic      [ACC_W-1:0]  acc_new,
  output logic                   in_range
);

  logic [ELEM_W-1:0] diff;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  cmp_val;

  always_comb begin
    diff     = (stored_elem > query_elem) ? (stored_elem - query_elem)
                                          : (query_elem - stored_elem);
    sum      = {1'b0, acc_old} + (ACC_W + 1)'(diff);
    acc_new  = (sum > ACC_LIMIT) ? ACC_LIMIT[ACC_W-1:0] : sum[ACC_W-1:0];
    // ignored element: compare the old sum untouched
    cmp_val  = ctl.pos_ok ? acc_new : acc_old;
    in_range = (cmp_val <= ctl.dist_limit);
  end

endmodule

`default_nettype wire

// ===== rtl/sad_signature_dedup_table.sv =====
// ----------------------------------------------------------------------------
// sad_signature_dedup_table
// Near-duplicate filter: SAD of a streamed query signature against a table.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signature element per request. in_tdata[4:0] element value,
//           in_tlast marks the final element, in_tuser is the opcode
//           (0 query, 1 query and insert when nothing similar is stored and the table has room).
//   out_* : one result request per signature, issued after the last element.
//   cfg_* : cfg_we writes the distance limit from cfg_wdata; write only when idle.
// Elements: each element inside the signature makes an accumulator
//   read-modify-write per stored entry through the store and accumulator
//   RAMs, plus pipeline fill; no new element is taken until that walk is done.
// Last element: each entry's distance is checked during the walk before the
//   result; an insert first copies the query buffer into the store, one
//   element per cycle through the single query buffer read port.
// Reset clears the entry count, position and accumulator valid flags at once;
//   no clearing pass is needed. Stored signatures are never read unwritten.
// A stalled receiver holds the result in the output register; the block
//   keeps taking elements and only waits if a second result is ready first.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_signature_dedup_table import sddt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // element request
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [4:0] element_value
  input  wire logic             in_tlast,   // is_last
  input  wire logic             in_tuser,   // opcode
  // result request
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [15:0]      out_tdata,  // [0] similar_found, [1] was_inserted,
                                            // [2] table_full, [9:3] entries_used
  // configuration
  input  wire logic             cfg_we,
  input  wire logic [ACC_W-1:0] cfg_wdata   // distance limit
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACC    = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  // control state
  logic [2:0]             state_r, state_nxt;
  logic [PCNT_W-1:0]      pos_r, pos_nxt;      // elements received
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;      // stored entries
  logic [CNT_W-1:0]       iss_e_r, iss_e_nxt;  // entry being issued
  logic                   st_v_r, st_v_nxt;    // RAM read data valid
  logic [PCNT_W-1:0]      cp_r, cp_nxt;        // copy issue position
  logic                   cv_r, cv_nxt;        // copy write valid
  logic                   last_r, last_nxt;
  logic                   op_r, op_nxt;
  logic                   pok_r, pok_nxt;
  logic                   sim_r, sim_nxt;
  logic                   ins_r, ins_nxt;
  logic                   full_r, full_nxt;
  logic [MAX_ENTRIES-1:0] acc_vld_r, acc_vld_nxt;
  logic [ACC_W-1:0]       max_dist_r, max_dist_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;

  // payload
  logic [ELEM_W-1:0]      v_r, v_nxt;
  logic [POS_W-1:0]       p_r, p_nxt;
  logic [ENTRY_W-1:0]     st_e_r, st_e_nxt;
  logic [POS_W-1:0]       cp_d_r, cp_d_nxt;
  logic [15:0]            out_tdata_r, out_tdata_nxt;

  logic                   in_acc;
  logic                   pos_ok_now;
  logic                   issue;
  logic                   cp_issue;
  logic                   out_free;

  logic [ELEM_W-1:0]      q_rd, s_rd;
  logic [ACC_W-1:0]       a_rd, acc_old, acc_new;
  logic                   in_range;
  sddt_ctl_t              ctl;

  logic                   sig_we;
  logic [ELEM_W-1:0]      sig_wdata;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign pos_ok_now = (pos_r < PCNT_W'(SIG_LEN));
  assign issue      = (iss_e_r < cnt_r);
  assign cp_issue   = (cp_r < PCNT_W'(SIG_LEN));
  assign out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------------------
  // Memories: query buffer, signature store, distance accumulators
  // ---------------------------------------------------------------------------
  sddt_ram #(.WIDTH(ELEM_W), .DEPTH(SIG_LEN)) u_qbuf (
    .clk   (clk),
    .we    (in_acc && pos_ok_now),
    .waddr (pos_r[POS_W-1:0]),
    .wdata (in_tdata[ELEM_W-1:0]),
    .raddr (cp_r[POS_W-1:0]),
    .rdata (q_rd)
  );

  // positions beyond the received length are stored as zero
  assign sig_we    = cv_r;
  assign sig_wdata = (PCNT_W'(cp_d_r) < pos_r) ? q_rd : '0;

  sddt_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (sig_we),
    .waddr ({cnt_r[ENTRY_W-1:0], cp_d_r}),
    .wdata (sig_wdata),
    .raddr ({iss_e_r[ENTRY_W-1:0], p_r}),
    .rdata (s_rd)
  );

  // read at entry e, written back in the following cycle; next read is e + 1,
  // so a read never meets its own pending write
  sddt_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ENTRIES)) u_acc (
    .clk   (clk),
    .we    (st_v_r && pok_r),
    .waddr (st_e_r),
    .wdata (acc_new),
    .raddr (iss_e_r[ENTRY_W-1:0]),
    .rdata (a_rd)
  );

  // invalid accumulator reads as zero (cleared after each query)
  assign acc_old        = acc_vld_r[st_e_r] ? a_rd : '0;
  assign ctl.pos_ok     = pok_r;
  assign ctl.dist_limit = max_dist_r;

  sddt_sad_unit u_sad (
    .ctl         (ctl),
    .stored_elem (s_rd),
    .query_elem  (v_r),
    .acc_old     (acc_old),
    .acc_new     (acc_new),
    .in_range    (in_range)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    iss_e_nxt      = iss_e_r;
    st_v_nxt       = 1'b0;
    cp_nxt         = cp_r;
    cv_nxt         = 1'b0;
    last_nxt       = last_r;
    op_nxt         = op_r;
    pok_nxt        = pok_r;
    sim_nxt        = sim_r;
    ins_nxt        = ins_r;
    full_nxt       = full_r;
    acc_vld_nxt    = acc_vld_r;
    max_dist_nxt   = cfg_we ? cfg_wdata : max_dist_r;
    out_tvalid_nxt = out_tvalid_r;
    v_nxt          = v_r;
    p_nxt          = p_r;
    st_e_nxt       = iss_e_r[ENTRY_W-1:0];
    cp_d_nxt       = cp_r[POS_W-1:0];
    out_tdata_nxt  = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          v_nxt     = in_tdata[ELEM_W-1:0];
          p_nxt     = pos_r[POS_W-1:0];
          last_nxt  = in_tlast;
          op_nxt    = in_tuser;
          pok_nxt   = pos_ok_now;
          sim_nxt   = 1'b0;
          ins_nxt   = 1'b0;
          full_nxt  = 1'b0;
          iss_e_nxt = '0;
          if (pos_ok_now) begin
            pos_nxt = pos_r + 1'b1;
          end
          // a walk is needed to accumulate, or on the last element to compare
          if ((pos_ok_now || in_tlast) && (cnt_r != '0)) begin
            state_nxt = S_ACC;
          end else if (in_tlast) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_ACC: begin
        st_v_nxt = issue;
        if (issue) begin
          iss_e_nxt = iss_e_r + 1'b1;
        end
        if (st_v_r) begin
          if (pok_r) begin
            acc_vld_nxt[st_e_r] = 1'b1;
          end
          if (last_r && in_range) begin
            sim_nxt = 1'b1;
          end
        end
        if (!issue && !st_v_r) begin
          state_nxt = last_r ? S_EVAL : S_IDLE;
        end
      end
      S_EVAL: begin
        state_nxt = S_RESULT;
        if (op_r && !sim_r) begin
          if (cnt_r < CNT_W'(MAX_ENTRIES)) begin
            ins_nxt   = 1'b1;
            cp_nxt    = '0;
            state_nxt = S_COPY;
          end else begin
            full_nxt = 1'b1;
          end
        end
      end
      S_COPY: begin
        cv_nxt = cp_issue;
        if (cp_issue) begin
          cp_nxt = cp_r + 1'b1;
        end
        if (!cp_issue && !cv_r) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'b0, cnt_r[6:0], full_r, ins_r, sim_r};
          pos_nxt        = '0;
          acc_vld_nxt    = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      cnt_r        <= '0;
      iss_e_r      <= '0;
      st_v_r       <= 1'b0;
      cp_r         <= '0;
      cv_r         <= 1'b0;
      last_r       <= 1'b0;
      op_r         <= 1'b0;
      pok_r        <= 1'b0;
      sim_r        <= 1'b0;
      ins_r        <= 1'b0;
      full_r       <= 1'b0;
      acc_vld_r    <= '0;
      max_dist_r   <= MAX_DIST_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      cnt_r        <= cnt_nxt;
      iss_e_r      <= iss_e_nxt;
      st_v_r       <= st_v_nxt;
      cp_r         <= cp_nxt;
      cv_r         <= cv_nxt;
      last_r       <= last_nxt;
      op_r         <= op_nxt;
      pok_r        <= pok_nxt;
      sim_r        <= sim_nxt;
      ins_r        <= ins_nxt;
      full_r       <= full_nxt;
      acc_vld_r    <= acc_vld_nxt;
      max_dist_r   <= max_dist_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    p_r         <= p_nxt;
    st_e_r      <= st_e_nxt;
    cp_d_r      <= cp_d_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // accumulator write-back only happens inside the entry walk
  a_acc_wr_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r |-> (state_r == S_ACC))
    else $error("accumulator write outside entry walk");

  // store is written only while copying the query buffer
  a_store_wr_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    sig_we |-> (state_r == S_COPY))
    else $error("signature store written outside copy");

  // entry count stays within table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds table size");

  // a result never reports both an insert and a full table
  a_ins_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[1] && out_tdata_r[2]))
    else $error("insert and full flagged together");

  // an inserted query bumps the entry count by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY && state_nxt == S_RESULT) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not advance entry count");

endmodule

`default_nettype wire
